/* design/extended_microsecond_timer_alarm_core_defines.svh */
// Assertion macros shared by the extended microsecond timer alarm core.
`ifndef EXTENDED_MICROSECOND_TIMER_ALARM_CORE_DEFINES_SVH
`define EXTENDED_MICROSECOND_TIMER_ALARM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EMTA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EMTA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/emta_pkg.sv */
// Shared types, codes and constants of the extended microsecond timer alarm core.
`default_nettype none

package emta_pkg;

    localparam int EMTA_COUNTER_BITS  = 16;
    localparam int EMTA_PRESCALE_BITS = 8;

    localparam int TIME_W  = 64;
    localparam int DELTA_W = 16;
    localparam int REM_W   = 16;
    localparam int PDIV_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_IN_W  = 88;
    localparam int TDATA_OUT_W = 88;

    localparam logic [PDIV_W-1:0]  PRESCALE_DIV_RESET = 8'd47;
    localparam logic [DELTA_W-1:0] MAX_SLEEP_RESET    = 16'd10000;
    localparam logic [DELTA_W-1:0] STEAL_MIN_RESET    = 16'd1000;
    localparam logic [DELTA_W-1:0] STEAL_MAX_RESET    = 16'hFFFF;
    localparam logic [DELTA_W-1:0] MIN_DELTA          = 16'd10;
    localparam int                 COMPARE_RESET      = 5000;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_READ     = 3'd1,
        OP_SET_TIME = 3'd2,
        OP_ARM      = 3'd3,
        OP_STEAL    = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE_DIV = 2'd0,
        CFG_MAX_SLEEP    = 2'd1,
        CFG_STEAL_MIN    = 2'd2,
        CFG_STEAL_MAX    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic fired;
        logic stolen;
        logic armed;
        logic armed_next;
    } alarm_status_t;

endpackage

`default_nettype wire

/* design/emta_timebase.sv */
// Prescaler, microsecond counter and 64-bit running time of the timer core.
`default_nettype none

module emta_timebase
    import emta_pkg::*;
#(
    parameter int COUNTER_BITS  = EMTA_COUNTER_BITS,
    parameter int PRESCALE_BITS = EMTA_PRESCALE_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire op_t                     op,
    input  wire logic [TIME_W-1:0]       new_time,
    input  wire logic [PDIV_W-1:0]       prescale_div,
    output logic [COUNTER_BITS-1:0]      micro_count,
    output logic [COUNTER_BITS-1:0]      micro_count_next,
    output logic                         us_step,
    output logic [TIME_W-1:0]            time_us_next
);

    localparam int PEXT_W = (PRESCALE_BITS > PDIV_W) ? PRESCALE_BITS : PDIV_W;

    logic [PRESCALE_BITS-1:0] prescale_count_reg;
    logic [PRESCALE_BITS-1:0] prescale_count_next;
    logic [COUNTER_BITS-1:0]  micro_count_reg;
    logic [TIME_W-1:0]        time_us_reg;
    logic [PEXT_W-1:0]        div_ext;
    logic [PRESCALE_BITS-1:0] div_masked;
    logic                     is_tick;
    logic                     period_done;
    logic                     is_set;

    // The running time is kept as one 64-bit register: a counter advance always adds one
    // microsecond, including the advance where the microsecond counter wraps.
    always_comb
    begin
        div_ext     = PEXT_W'(prescale_div);
        div_masked  = div_ext[PRESCALE_BITS-1:0];
        is_tick     = step && (op == OP_TICK);
        is_set      = step && (op == OP_SET_TIME);
        period_done = (prescale_count_reg >= div_masked);
        us_step     = is_tick && period_done;

        prescale_count_next = prescale_count_reg;
        if (is_tick)
        begin
            prescale_count_next = period_done ? '0 : prescale_count_reg + 1'b1;
        end

        micro_count_next = micro_count_reg;
        time_us_next     = time_us_reg;
        if (us_step)
        begin
            micro_count_next = micro_count_reg + 1'b1;
            time_us_next     = time_us_reg + 64'd1;
        end
        else if (is_set)
        begin
            micro_count_next = '0;
            time_us_next     = new_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            micro_count_reg    <= '0;
            time_us_reg        <= '0;
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            micro_count_reg    <= micro_count_next;
            time_us_reg        <= time_us_next;
        end
    end

    assign micro_count = micro_count_reg;

endmodule

`default_nettype wire

/* design/emta_alarm.sv */
// One-shot compare alarm with arm and steal operations.
`default_nettype none

module emta_alarm
    import emta_pkg::*;
#(
    parameter int COUNTER_BITS = EMTA_COUNTER_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire op_t                     op,
    input  wire logic [DELTA_W-1:0]      alarm_delta,
    input  wire logic                    use_max_sleep,
    input  wire logic                    has_callback,
    input  wire logic [COUNTER_BITS-1:0] micro_count,
    input  wire logic [COUNTER_BITS-1:0] micro_count_next,
    input  wire logic                    us_step,
    input  wire logic [DELTA_W-1:0]      max_sleep_us,
    input  wire logic [DELTA_W-1:0]      steal_min_us,
    input  wire logic [DELTA_W-1:0]      steal_max_us,
    output alarm_status_t                status,
    output logic [REM_W-1:0]             remaining_us
);

    localparam int W = (COUNTER_BITS > DELTA_W) ? COUNTER_BITS : DELTA_W;

    logic [COUNTER_BITS-1:0] compare_reg;
    logic [COUNTER_BITS-1:0] compare_next;
    logic                    armed_reg;
    logic                    armed_next;
    logic [DELTA_W-1:0]      delta;
    logic [W-1:0]            arm_sum;
    logic [COUNTER_BITS-1:0] rem_cnt;
    logic [W-1:0]            rem_ext;
    logic                    in_window;
    logic                    fired;
    logic                    stolen;

    always_comb
    begin
        if (use_max_sleep)
        begin
            delta = max_sleep_us;
        end
        else
        begin
            delta = (alarm_delta < MIN_DELTA) ? MIN_DELTA : alarm_delta;
        end
        arm_sum   = W'(micro_count) + W'(delta);
        rem_cnt   = compare_reg - micro_count;
        rem_ext   = W'(rem_cnt);
        in_window = (rem_ext >= W'(steal_min_us)) && (rem_ext <= W'(steal_max_us));

        compare_next = compare_reg;
        armed_next   = armed_reg;
        fired        = 1'b0;
        stolen       = 1'b0;
        remaining_us = '0;

        if (step)
        begin
            case (op)
                OP_TICK:
                begin
                    // A match counts only on the cycle the counter advances.
                    if (us_step && armed_reg && (micro_count_next == compare_reg))
                    begin
                        fired      = 1'b1;
                        armed_next = 1'b0;
                    end
                end
                OP_ARM:
                begin
                    compare_next = arm_sum[COUNTER_BITS-1:0];
                    armed_next   = has_callback;
                end
                OP_STEAL:
                begin
                    remaining_us = rem_ext[REM_W-1:0];
                    if (armed_reg && in_window)
                    begin
                        stolen     = 1'b1;
                        armed_next = 1'b0;
                    end
                end
                default:
                begin
                    compare_next = compare_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg <= COUNTER_BITS'(COMPARE_RESET);
            armed_reg   <= 1'b0;
        end
        else
        begin
            compare_reg <= compare_next;
            armed_reg   <= armed_next;
        end
    end

    always_comb
    begin
        status.fired      = fired;
        status.stolen     = stolen;
        status.armed      = armed_reg;
        status.armed_next = armed_next;
    end

endmodule

`default_nettype wire

/* design/extended_microsecond_timer_alarm_core.sv */
// Top level of the extended microsecond timer alarm core.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  one operation beat (tick, read, set, arm, steal)
//  m_*       out        m_tvalid / m_tready  one result beat for every operation beat
//  cfg_*     in         cfg_we               register writes, no read-back
//
// Every operation beat produces exactly one result beat; after it is accepted
// it passes through the input register and then the result register.
// Sustained rate is one beat per cycle while m_tready stays high; the only loop
// is the state update (prescaler, counter, 64-bit time incrementer, alarm compare).
// Reset is asynchronous and active low; it clears the timebase, disarms the
// alarm, loads the compare value and restores the configuration defaults.
// When m_tready is low with a full result register, the input register holds
// its beat and s_tready drops once that register is occupied as well.
`default_nettype none

`include "extended_microsecond_timer_alarm_core_defines.svh"

module extended_microsecond_timer_alarm_core
    import emta_pkg::*;
#(
    parameter int COUNTER_BITS  = EMTA_COUNTER_BITS,
    parameter int PRESCALE_BITS = EMTA_PRESCALE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Operation stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [63:0] new_time, [79:64] alarm_delta, [80] use_max_sleep,
    // [81] has_callback, [87:82] zero
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,
    // [2:0] operation
    input  wire logic [2:0]             s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [63:0] time_us, [64] alarm_fired, [65] stolen, [81:66] remaining_us,
    // [82] alarm_armed, [87:83] zero
    output logic [TDATA_OUT_W-1:0]      m_tdata,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    // Configuration registers.
    logic [PDIV_W-1:0]  prescale_div_reg;
    logic [DELTA_W-1:0] max_sleep_reg;
    logic [DELTA_W-1:0] steal_min_reg;
    logic [DELTA_W-1:0] steal_max_reg;

    // Input register.
    logic               in_valid_reg;
    logic               in_valid_next;
    op_t                op_reg;
    logic [TIME_W-1:0]  new_time_reg;
    logic [DELTA_W-1:0] alarm_delta_reg;
    logic               use_max_sleep_reg;
    logic               has_callback_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [TIME_W-1:0]  time_us_reg;
    logic               alarm_fired_reg;
    logic               stolen_reg;
    logic [REM_W-1:0]   remaining_reg;
    logic               alarm_armed_reg;

    logic                    in_accept;
    logic                    advance;
    logic [COUNTER_BITS-1:0] micro_count;
    logic [COUNTER_BITS-1:0] micro_count_next;
    logic                    us_step;
    logic [TIME_W-1:0]       time_us_next;
    alarm_status_t           alarm_st;
    logic [REM_W-1:0]        remaining_us;

    // The held beat moves on whenever the result register is free or drained.
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        in_accept      = s_tvalid && s_tready;
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg <= PRESCALE_DIV_RESET;
            max_sleep_reg    <= MAX_SLEEP_RESET;
            steal_min_reg    <= STEAL_MIN_RESET;
            steal_max_reg    <= STEAL_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRESCALE_DIV: prescale_div_reg <= cfg_data[PDIV_W-1:0];
                CFG_MAX_SLEEP:    max_sleep_reg    <= cfg_data;
                CFG_STEAL_MIN:    steal_min_reg    <= cfg_data;
                CFG_STEAL_MAX:    steal_max_reg    <= cfg_data;
                default:          prescale_div_reg <= prescale_div_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg            <= op_t'(s_tuser);
            new_time_reg      <= s_tdata[63:0];
            alarm_delta_reg   <= s_tdata[79:64];
            use_max_sleep_reg <= s_tdata[80];
            has_callback_reg  <= s_tdata[81];
        end
        if (advance)
        begin
            time_us_reg     <= time_us_next;
            alarm_fired_reg <= alarm_st.fired;
            stolen_reg      <= alarm_st.stolen;
            remaining_reg   <= remaining_us;
            alarm_armed_reg <= alarm_st.armed_next;
        end
    end

    emta_timebase #(
        .COUNTER_BITS  (COUNTER_BITS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_timebase (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .op               (op_reg),
        .new_time         (new_time_reg),
        .prescale_div     (prescale_div_reg),
        .micro_count      (micro_count),
        .micro_count_next (micro_count_next),
        .us_step          (us_step),
        .time_us_next     (time_us_next)
    );

    emta_alarm #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_alarm (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .op               (op_reg),
        .alarm_delta      (alarm_delta_reg),
        .use_max_sleep    (use_max_sleep_reg),
        .has_callback     (has_callback_reg),
        .micro_count      (micro_count),
        .micro_count_next (micro_count_next),
        .us_step          (us_step),
        .max_sleep_us     (max_sleep_reg),
        .steal_min_us     (steal_min_reg),
        .steal_max_us     (steal_max_reg),
        .status           (alarm_st),
        .remaining_us     (remaining_us)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, alarm_armed_reg, remaining_reg, stolen_reg,
                       alarm_fired_reg, time_us_reg};

    // Both registers full and the sink stalled: nothing new may be taken.
    `EMTA_ASSERT_IMP(a_no_accept_when_full, in_valid_reg && out_valid_reg && !m_tready, !s_tready, "beat accepted while both stages were full")
    // A set-time beat shows exactly the loaded time in its result.
    `EMTA_ASSERT_NXT(a_set_time_result, advance && (op_reg == OP_SET_TIME), time_us_reg == $past(new_time_reg), "set time result does not match loaded time")
    // The alarm only disarms while a beat is being processed.
    `EMTA_ASSERT_IMP(a_disarm_on_beat, $fell(alarm_st.armed), $past(advance), "alarm disarmed without a processed beat")

endmodule

`default_nettype wire
